[rtl/core/ald_pkg.sv]
// Shared types and constants for the ambient light dimmer.
package ald_pkg;

    localparam int unsigned SAMPLE_W = 12;
    localparam int unsigned MV_W     = 12;
    localparam int unsigned THR_W    = 12;
    localparam int unsigned HYS_W    = 11;
    localparam int unsigned LEVEL_W  = 8;
    localparam int unsigned STATE_W  = 2;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 12;
    localparam int unsigned PROD_W   = 24;

    // full scale in mV over 2^12 converter codes
    localparam logic [MV_W-1:0] MV_SCALE = 12'd3300;

    localparam logic [THR_W-1:0]   THR_RESET    = 12'd1000;
    localparam logic [HYS_W-1:0]   HYS_RESET    = 11'd100;
    localparam logic [LEVEL_W-1:0] BRIGHT_RESET = 8'd255;
    localparam logic [LEVEL_W-1:0] DIM_RESET    = 8'd0;

    typedef enum logic [STATE_W-1:0] {
        LIGHT_UNDECIDED = 2'd0,
        LIGHT_DARK      = 2'd1,
        LIGHT_BRIGHT    = 2'd2,
        LIGHT_RSVD      = 2'd3
    } t_light;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD  = 2'd0,
        CFG_HYSTERESIS = 2'd1,
        CFG_BRIGHT     = 2'd2,
        CFG_DIM        = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WRITE,
        S_READ,
        S_DRAIN,
        S_DECIDE
    } t_state;

endpackage

[rtl/core/ald_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module ald_ram #(
    parameter int unsigned WIDTH = 12,
    parameter int unsigned DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/ambient_light_dimmer_top.sv]
// Top level of the ambient light dimmer: sample ring, halving average, threshold.
//
// Usage:
//   Slave stream (i_s_*) takes one raw 12-bit light sample per transfer.
//   Master stream (o_m_*) gives one result per sample: average in mV, light
//   state, update flag and the brightness to drive when update is set.
//   Config channel (i_cfg_*) writes threshold, hysteresis, bright and dim
//   levels; o_cfg_ready is always high, write only while the block is idle.
// Timing:
//   A result reaches the output register after its transfer by one ring write,
//   DEPTH ring reads through the registered RAM read port, the drain state and
//   the compare state; the mV multiply sits in the transfer cycle. One sample
//   in work at a time: a new one is taken once the last result is loaded.
// Reset:
//   Synchronous, active low. Ring entries read as zero until written (per-entry
//   valid flops), write slot and light state go to zero, registers take their
//   default values. No clearing pass is needed.
// Stall:
//   A result waits in the output register; the next sample is still accepted
//   and worked on, and only its final compare step waits for the register.
module ambient_light_dimmer_top #(
    parameter int unsigned DEPTH = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // slave stream; tdata: [11:0] sample, [15:12] zero
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [15:0]                   i_s_tdata,
    // master stream; tdata: [11:0] average_mv, [13:12] light_state,
    // [14] update, [22:15] drive_level, [23] zero
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [23:0]                   o_m_tdata,
    // configuration write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [ald_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ald_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    import ald_pkg::*;

    localparam int unsigned AW = $clog2(DEPTH);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    t_state r_state, n_state;

    logic [THR_W-1:0]   r_threshold;
    logic [HYS_W-1:0]   r_hysteresis;
    logic [LEVEL_W-1:0] r_bright;
    logic [LEVEL_W-1:0] r_dim;

    logic [MV_W-1:0]    r_mv;
    logic [AW-1:0]      r_slot;
    logic [DEPTH-1:0]   r_valid;
    logic [AW-1:0]      r_rd_addr;
    logic               r_rd_pend;
    logic               r_rd_ok;
    logic               r_rd_first;
    logic               r_done;
    logic [MV_W-1:0]    r_acc;
    t_light             r_level;

    logic               r_out_valid;
    logic [23:0]        r_out_data;

    logic               s_accept;
    logic               ram_we;
    logic               rd_issue;
    logic               out_free;
    logic               out_load;
    logic [PROD_W-1:0]  prod;
    logic [MV_W-1:0]    rd_val;
    logic [MV_W:0]      acc_sum;
    logic [THR_W:0]     upper;
    logic [THR_W:0]     avg_plus_hys;
    logic               go_bright;
    logic               go_dark;
    t_light             new_level;
    logic               upd;
    logic [LEVEL_W-1:0] drive;

    ald_ram #(
        .WIDTH(MV_W),
        .DEPTH(DEPTH)
    ) u_ring (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_slot),
        .i_wdata(r_mv),
        .i_raddr(r_rd_addr),
        .o_rdata(rd_val)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_s_tvalid) n_state = S_WRITE;
            S_WRITE:  n_state = S_READ;
            S_READ:   if (r_rd_addr == LAST_ADDR) n_state = S_DRAIN;
            S_DRAIN:  n_state = S_DECIDE;
            S_DECIDE: if (out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // control outputs of the sequencer
    always_comb begin
        o_s_tready = 1'b0;
        ram_we     = 1'b0;
        rd_issue   = 1'b0;
        out_load   = 1'b0;
        unique case (r_state)
            S_IDLE:   o_s_tready = 1'b1;
            S_WRITE:  ram_we     = 1'b1;
            S_READ:   rd_issue   = 1'b1;
            S_DRAIN:  ;
            S_DECIDE: out_load   = out_free;
            default:  ;
        endcase
    end

    assign s_accept = i_s_tvalid & o_s_tready;
    assign out_free = ~r_out_valid | i_m_tready;
    assign prod     = PROD_W'(i_s_tdata[SAMPLE_W-1:0]) * PROD_W'(MV_SCALE);
    assign acc_sum  = {1'b0, r_acc} + {1'b0, rd_val};

    // dead band compare; lower edge written as avg + hys < thr to stay unsigned
    assign upper        = {1'b0, r_threshold} + (THR_W+1)'(r_hysteresis);
    assign avg_plus_hys = {1'b0, r_acc} + (THR_W+1)'(r_hysteresis);
    assign go_bright    = ({1'b0, r_acc} > upper) && (r_level != LIGHT_BRIGHT);
    assign go_dark      = (avg_plus_hys < {1'b0, r_threshold}) && (r_level != LIGHT_DARK);

    always_comb begin
        priority if (go_bright) begin
            new_level = LIGHT_BRIGHT;
            upd       = 1'b1;
            drive     = r_bright;
        end else if (go_dark) begin
            new_level = LIGHT_DARK;
            upd       = 1'b1;
            drive     = r_dim;
        end else begin
            new_level = r_level;
            upd       = 1'b0;
            drive     = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_threshold  <= THR_RESET;
            r_hysteresis <= HYS_RESET;
            r_bright     <= BRIGHT_RESET;
            r_dim        <= DIM_RESET;
            r_slot       <= '0;
            r_valid      <= '0;
            r_rd_addr    <= '0;
            r_rd_pend    <= 1'b0;
            r_level      <= LIGHT_UNDECIDED;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_valid) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_THRESHOLD:  r_threshold  <= i_cfg_data[THR_W-1:0];
                    CFG_HYSTERESIS: r_hysteresis <= i_cfg_data[HYS_W-1:0];
                    CFG_BRIGHT:     r_bright     <= i_cfg_data[LEVEL_W-1:0];
                    CFG_DIM:        r_dim        <= i_cfg_data[LEVEL_W-1:0];
                    default:        ;
                endcase
            end

            if (ram_we) begin
                r_valid[r_slot] <= 1'b1;
                r_slot          <= (r_slot == LAST_ADDR) ? '0 : r_slot + 1'b1;
                r_rd_addr       <= '0;
            end

            r_rd_pend <= rd_issue;
            if (rd_issue && r_rd_addr != LAST_ADDR) begin
                r_rd_addr <= r_rd_addr + 1'b1;
            end

            if (out_load) begin
                r_level     <= new_level;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload and datapath registers
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_mv <= prod[PROD_W-1:PROD_W-MV_W];
        end

        if (rd_issue) begin
            r_rd_ok    <= r_valid[r_rd_addr];
            r_rd_first <= (r_rd_addr == '0);
        end

        // halving average; stops at the first empty or zero entry after entry 0
        if (r_rd_pend) begin
            if (r_rd_first) begin
                r_acc  <= r_rd_ok ? rd_val : '0;
                r_done <= 1'b0;
            end else if (!r_done) begin
                if (!r_rd_ok || rd_val == '0) begin
                    r_done <= 1'b1;
                end else begin
                    r_acc <= acc_sum[MV_W:1];
                end
            end
        end

        if (out_load) begin
            r_out_data <= {1'b0, drive, upd, new_level, r_acc};
        end
    end

    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out_data;
    assign o_cfg_ready = 1'b1;

endmodule
